// ===== hw/rtl/pal_pkg.sv =====
`timescale 1ns / 1ps

package pal_pkg;

	localparam int MAX_PAGES  = 16384;
	localparam int PAGE_W     = $clog2(MAX_PAGES);
	localparam int DEPTH_W    = PAGE_W + 1;
	localparam int COUNT_BITS = 8;
	localparam int REF_W      = 8;
	localparam int STATUS_W   = 2;
	localparam int CFG_IDX_W  = 1;
	localparam int CFG_DATA_W = DEPTH_W;

	localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

	// command queue between front and back
	localparam int QDEPTH = 2;
	localparam int QPTR_W = $clog2(QDEPTH);

	localparam logic [CFG_IDX_W-1:0] CFG_FIRST_PAGE = 1'b0;
	localparam logic [CFG_IDX_W-1:0] CFG_PAGE_LIMIT = 1'b1;

	typedef enum logic [1:0] {
		OP_ALLOC  = 2'd0,
		OP_FREE   = 2'd1,
		OP_INCREF = 2'd2,
		OP_DECREF = 2'd3
	} opcode_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_EMPTY = 2'd1,
		ST_RANGE = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	typedef enum logic [1:0] {
		BK_CLEAR,
		BK_IDLE,
		BK_EXEC
	} back_state_t;

	typedef struct packed {
		opcode_t           op;
		logic [PAGE_W-1:0] page;
		logic              range_ok;
	} pal_cmd_t;

	typedef struct packed {
		logic clearing;
	} pal_back_stat_t;

endpackage

// ===== hw/rtl/page_allocator_refcount.sv =====
`timescale 1ns / 1ps

// Page allocator with per-page reference counts.
//
// Command side is a queue: drive opcode/page_index, raise push; the item is
// taken on a clock edge with push high and full low. Result side is a single
// register: while empty is low the result sits on alloc_page, status,
// ref_count and page_freed, and pop with empty low takes it.
// Config: cfg_valid/cfg_ready with cfg_index (0 first_page, 1 page_limit)
// and cfg_data; cfg_ready is always high. Write only while idle.
//
// Each item is read in IDLE (count table and stack top), then executed
// and written back in EXEC; both memories have one port each. The back
// end takes no new item until EXEC is done. A 2-entry command queue keeps
// accepting while the back end or the result register is stalled; full
// rises once it fills.
// Reset: after arst_n releases, the count table is cleared one entry per
// cycle, all 16384 entries, during which full stays high. The free stack
// starts empty; seed it with free commands.
module page_allocator_refcount (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          push,
	output logic                          full,
	input  logic [1:0]                    opcode,
	input  logic [pal_pkg::PAGE_W-1:0]    page_index,
	output logic                          empty,
	input  logic                          pop,
	output logic [pal_pkg::PAGE_W-1:0]    alloc_page,
	output logic [pal_pkg::STATUS_W-1:0]  status,
	output logic [pal_pkg::REF_W-1:0]     ref_count,
	output logic                          page_freed,
	input  logic                          cfg_valid,
	output logic                          cfg_ready,
	input  logic [pal_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [pal_pkg::CFG_DATA_W-1:0] cfg_data
);
	import pal_pkg::*;

	logic [PAGE_W-1:0]   first_page_q;
	logic [DEPTH_W-1:0]  page_limit_q;
	logic                cmd_valid, cmd_pop;
	pal_cmd_t            cmd;
	pal_back_stat_t      back_stat;

	// config registers, always ready
	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_page_q <= '0;
			page_limit_q <= DEPTH_W'(MAX_PAGES);
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_FIRST_PAGE: first_page_q <= cfg_data[PAGE_W-1:0];
				CFG_PAGE_LIMIT: page_limit_q <= cfg_data;
				default: ;
			endcase
		end
	end

	// front: accept, range check, command queue
	pal_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.page_index (page_index),
		.first_page (first_page_q),
		.page_limit (page_limit_q),
		.back_stat  (back_stat),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	// back: stack, count table, result register
	pal_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop),
		.back_stat  (back_stat),
		.empty      (empty),
		.pop        (pop),
		.alloc_page (alloc_page),
		.status     (status),
		.ref_count  (ref_count),
		.page_freed (page_freed)
	);

	// failed alloc reports nothing handed out
	a_empty_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_EMPTY) |-> (alloc_page == '0 && ref_count == '0 && !page_freed))
		else $error("out-of-pages result carries data");

	// range error touches no page
	a_range_clean: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && status == ST_RANGE) |-> (alloc_page == '0 && ref_count == '0 && !page_freed))
		else $error("range error result carries data");

	// a push only happens on success
	a_freed_ok: assert property (@(posedge clk) disable iff (!arst_n)
		(!empty && page_freed) |-> (status == ST_OK && alloc_page == '0))
		else $error("page_freed with error status");

	// no commands taken during the clear pass
	a_clear_blocks: assert property (@(posedge clk) disable iff (!arst_n)
		back_stat.clearing |-> (full && empty))
		else $error("item moved during count clear");

endmodule

// ===== hw/rtl/pal_front.sv =====
`timescale 1ns / 1ps

module pal_front (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         push,
	output logic                         full,
	input  logic [1:0]                   opcode,
	input  logic [pal_pkg::PAGE_W-1:0]   page_index,
	input  logic [pal_pkg::PAGE_W-1:0]   first_page,
	input  logic [pal_pkg::DEPTH_W-1:0]  page_limit,
	input  pal_pkg::pal_back_stat_t      back_stat,
	output logic                         cmd_valid,
	output pal_pkg::pal_cmd_t            cmd,
	input  logic                         cmd_pop
);
	import pal_pkg::*;

	pal_cmd_t            q_mem [QDEPTH];
	logic [QPTR_W-1:0]   wr_q, rd_q;
	logic [QPTR_W:0]     cnt_q;
	pal_cmd_t            new_cmd;
	logic                wr_en, rd_en;

	// classify at accept; the user must keep config stable while items are in flight, the block does not check it
	always_comb begin
		new_cmd.op       = opcode_t'(opcode);
		new_cmd.page     = page_index;
		new_cmd.range_ok = (page_index >= first_page) &&
		                   ({1'b0, page_index} < page_limit);
	end

	assign full      = (cnt_q == (QPTR_W+1)'(QDEPTH)) || back_stat.clearing;
	assign wr_en     = push && !full;
	assign cmd_valid = (cnt_q != '0);
	assign rd_en     = cmd_pop && cmd_valid;
	assign cmd       = q_mem[rd_q];

	always_ff @(posedge clk) begin
		if (wr_en) q_mem[wr_q] <= new_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= '0;
			rd_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (wr_en) wr_q <= wr_q + 1'b1;
			if (rd_en) rd_q <= rd_q + 1'b1;
			case ({wr_en, rd_en})
				2'b10:   cnt_q <= cnt_q + 1'b1;
				2'b01:   cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

// ===== hw/rtl/pal_back.sv =====
`timescale 1ns / 1ps

module pal_back (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cmd_valid,
	input  pal_pkg::pal_cmd_t             cmd,
	output logic                          cmd_pop,
	output pal_pkg::pal_back_stat_t       back_stat,
	output logic                          empty,
	input  logic                          pop,
	output logic [pal_pkg::PAGE_W-1:0]    alloc_page,
	output logic [pal_pkg::STATUS_W-1:0]  status,
	output logic [pal_pkg::REF_W-1:0]     ref_count,
	output logic                          page_freed
);
	import pal_pkg::*;

	back_state_t             state_q, state_d;
	logic                    start, done, clr_we;
	logic [PAGE_W-1:0]       clr_q;

	logic [COUNT_BITS-1:0]   count_mem [MAX_PAGES];
	logic [PAGE_W-1:0]       stack_mem [MAX_PAGES];
	logic [COUNT_BITS-1:0]   count_rd_q;
	logic [PAGE_W-1:0]       stack_rd_q;
	logic [PAGE_W-1:0]       stack_rd_addr;

	pal_cmd_t                cmd_q;
	logic [DEPTH_W-1:0]      depth_q;
	logic                    stack_full, stack_empty;

	logic                    out_valid_q;
	logic [PAGE_W-1:0]       apage_q;
	status_t                 status_q;
	logic [COUNT_BITS-1:0]   cnt_q;
	logic                    freed_q;

	status_t                 ex_status;
	logic [PAGE_W-1:0]       ex_apage;
	logic [COUNT_BITS-1:0]   ex_cnt;
	logic                    ex_freed, ex_push, ex_pop, ex_cnt_we;
	logic [PAGE_W-1:0]       ex_cnt_addr;
	logic [COUNT_BITS-1:0]   inc_c, dec_c;

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= BK_CLEAR;
		else         state_q <= state_d;
	end

	always_comb begin
		state_d = state_q;
		start   = 1'b0;
		done    = 1'b0;
		clr_we  = 1'b0;
		cmd_pop = 1'b0;
		case (state_q)
			BK_CLEAR: begin
				clr_we = 1'b1;
				if (clr_q == PAGE_W'(MAX_PAGES - 1)) state_d = BK_IDLE;
			end
			BK_IDLE: begin
				if (cmd_valid) begin
					start   = 1'b1;
					cmd_pop = 1'b1;
					state_d = BK_EXEC;
				end
			end
			BK_EXEC: begin
				if (!out_valid_q || pop) begin
					done    = 1'b1;
					state_d = BK_IDLE;
				end
			end
			default: state_d = BK_CLEAR;
		endcase
	end

	assign back_stat.clearing = (state_q == BK_CLEAR);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)     clr_q <= '0;
		else if (clr_we) clr_q <= clr_q + 1'b1;
	end

	// execute: read data from the start cycle is valid here
	assign stack_full    = (depth_q == DEPTH_W'(MAX_PAGES));
	assign stack_empty   = (depth_q == '0);
	assign stack_rd_addr = PAGE_W'(depth_q - 1'b1);
	assign inc_c = (count_rd_q == COUNT_MAX) ? count_rd_q : COUNT_BITS'(count_rd_q + 1'b1);
	assign dec_c = (count_rd_q == '0) ? count_rd_q : COUNT_BITS'(count_rd_q - 1'b1);

	always_comb begin
		ex_status   = ST_OK;
		ex_apage    = '0;
		ex_cnt      = '0;
		ex_freed    = 1'b0;
		ex_push     = 1'b0;
		ex_pop      = 1'b0;
		ex_cnt_we   = 1'b0;
		ex_cnt_addr = cmd_q.page;
		if (cmd_q.op == OP_ALLOC) begin
			if (stack_empty) begin
				ex_status = ST_EMPTY;
			end else begin
				ex_pop      = 1'b1;
				ex_apage    = stack_rd_q;
				ex_cnt_addr = stack_rd_q;
				ex_cnt_we   = 1'b1;
				ex_cnt      = COUNT_BITS'(1);
			end
		end else if (!cmd_q.range_ok) begin
			ex_status = ST_RANGE;
		end else begin
			case (cmd_q.op)
				OP_FREE: begin
					ex_cnt = count_rd_q;
					if (stack_full) begin
						ex_status = ST_FULL;
					end else begin
						ex_push  = 1'b1;
						ex_freed = 1'b1;
					end
				end
				OP_INCREF: begin
					ex_cnt    = inc_c;
					ex_cnt_we = 1'b1;
				end
				OP_DECREF: begin
					ex_cnt    = dec_c;
					ex_cnt_we = 1'b1;
					if (dec_c == '0) begin
						if (stack_full) begin
							ex_status = ST_FULL;
						end else begin
							ex_push  = 1'b1;
							ex_freed = 1'b1;
						end
					end
				end
				default: ex_status = ST_OK;
			endcase
		end
	end

	// count table, single write port, registered read
	always_ff @(posedge clk) begin
		if (clr_we)                 count_mem[clr_q] <= '0;
		else if (done && ex_cnt_we) count_mem[ex_cnt_addr] <= ex_cnt;
		if (start)                  count_rd_q <= count_mem[cmd.page];
	end

	// free stack
	always_ff @(posedge clk) begin
		if (done && ex_push) stack_mem[depth_q[PAGE_W-1:0]] <= cmd_q.page;
		if (start)           stack_rd_q <= stack_mem[stack_rd_addr];
	end

	always_ff @(posedge clk) begin
		if (start) cmd_q <= cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			depth_q <= '0;
		end else if (done) begin
			if (ex_push)     depth_q <= depth_q + 1'b1;
			else if (ex_pop) depth_q <= depth_q - 1'b1;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)                 out_valid_q <= 1'b0;
		else if (done)               out_valid_q <= 1'b1;
		else if (pop && out_valid_q) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (done) begin
			apage_q  <= ex_apage;
			status_q <= ex_status;
			cnt_q    <= ex_cnt;
			freed_q  <= ex_freed;
		end
	end

	assign empty      = !out_valid_q;
	assign alloc_page = apage_q;
	assign status     = status_q;
	assign ref_count  = REF_W'(cnt_q);
	assign page_freed = freed_q;

endmodule

// ===== sim/page_alloc_checker.sv =====
`timescale 1ns / 1ps

module page_alloc_checker (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           push,
	input  logic                           full,
	input  logic [1:0]                     opcode,
	input  logic [pal_pkg::PAGE_W-1:0]     page_index,
	input  logic                           pop,
	input  logic                           empty,
	input  logic [pal_pkg::PAGE_W-1:0]     alloc_page,
	input  logic [pal_pkg::STATUS_W-1:0]   status,
	input  logic [pal_pkg::REF_W-1:0]      ref_count,
	input  logic                           page_freed,
	input  logic                           cfg_valid,
	input  logic                           cfg_ready,
	input  logic [pal_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [pal_pkg::CFG_DATA_W-1:0] cfg_data,
	output int                             outstanding,
	output int                             fail_count,
	output int                             checked
);
	import pal_pkg::*;

	typedef struct packed {
		logic [PAGE_W-1:0] page;
		status_t           st;
		logic [REF_W-1:0]  cnt;
		logic              freed;
	} page_result_t;

	page_result_t pending_results[$];

	// shadow allocator state
	logic [PAGE_W-1:0]     free_pages[MAX_PAGES];
	logic [DEPTH_W-1:0]    free_top;
	logic [COUNT_BITS-1:0] refs[MAX_PAGES];
	logic [PAGE_W-1:0]     lo_page;
	logic [DEPTH_W-1:0]    hi_page;

	int mismatches = 0;
	int n_checked = 0;

	task automatic report_mismatch(input string what, input int got, input int want);
		mismatches++;
		if (mismatches <= 100)
			$display("[%0t] result %0d: %s got %0d, expected %0d",
				$time, n_checked, what, got, want);
	endtask

	task automatic push_free(input logic [PAGE_W-1:0] pg, inout page_result_t r);
		if (free_top == DEPTH_W'(MAX_PAGES)) begin
			r.st = ST_FULL;
		end else begin
			free_pages[free_top[PAGE_W-1:0]] = pg;
			free_top = free_top + 1'b1;
			r.freed = 1'b1;
		end
	endtask

	task automatic run_page_op(input opcode_t op, input logic [PAGE_W-1:0] pg,
			output page_result_t r);
		logic                  in_window;
		logic [COUNT_BITS-1:0] c;
		r.page = '0;
		r.st = ST_OK;
		r.cnt = '0;
		r.freed = 1'b0;
		in_window = (pg >= lo_page) && ({1'b0, pg} < hi_page);
		if (op == OP_ALLOC) begin
			if (free_top == '0) begin
				r.st = ST_EMPTY;
			end else begin
				free_top = free_top - 1'b1;
				r.page = free_pages[free_top[PAGE_W-1:0]];
				refs[r.page] = COUNT_BITS'(1);
				r.cnt = REF_W'(1);
			end
		end else if (!in_window) begin
			r.st = ST_RANGE;
		end else begin
			c = refs[pg];
			case (op)
				OP_FREE: begin
					push_free(pg, r);
				end
				OP_INCREF: begin
					if (c != COUNT_MAX)
						c = c + 1'b1;
					refs[pg] = c;
				end
				default: begin
					if (c != '0)
						c = c - 1'b1;
					refs[pg] = c;
					if (c == '0)
						push_free(pg, r);
				end
			endcase
			r.cnt = REF_W'(c);
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		page_result_t want;
		if (!arst_n) begin
			free_top = '0;
			lo_page = '0;
			hi_page = DEPTH_W'(MAX_PAGES);
			foreach (refs[i])
				refs[i] = '0;
			pending_results.delete();
			outstanding <= 0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				case (cfg_index)
					CFG_FIRST_PAGE: lo_page = cfg_data[PAGE_W-1:0];
					CFG_PAGE_LIMIT: hi_page = cfg_data;
					default: ;
				endcase
			end
			if (pop && !empty) begin
				if (pending_results.size() == 0) begin
					report_mismatch("result with nothing pending, status", status, -1);
				end else begin
					want = pending_results.pop_front();
					if (alloc_page !== want.page)
						report_mismatch("alloc_page", alloc_page, want.page);
					if (status !== want.st)
						report_mismatch("status", status, want.st);
					if (ref_count !== want.cnt)
						report_mismatch("ref_count", ref_count, want.cnt);
					if (page_freed !== want.freed)
						report_mismatch("page_freed", page_freed, want.freed);
				end
				n_checked++;
			end
			if (push && !full) begin
				run_page_op(opcode_t'(opcode), page_index, want);
				pending_results.push_back(want);
			end
			outstanding <= pending_results.size();
		end
		fail_count <= mismatches;
		checked <= n_checked;
	end

endmodule

// ===== sim/tb_page_allocator_refcount.sv =====
`timescale 1ns / 1ps

// Stimulus and verdict for the page allocator. The checker beside the DUT
// predicts every result; this module only drives the three channels.
module tb_page_allocator_refcount;
	import pal_pkg::*;

	localparam int TOP_PAGE = MAX_PAGES - 1;
	// The slowest correct run (clearing pass, ~2.1k items at worst-case gap +
	// stall, one long hold-off) stays far below this limit.
	localparam int LIMIT = 1_500_000;

	logic                  clk = 1'b0;
	logic                  arst_n = 1'b0;
	logic                  push = 1'b0;
	logic                  full;
	logic [1:0]            opcode = '0;
	logic [PAGE_W-1:0]     page_index = '0;
	logic                  empty;
	logic                  pop = 1'b0;
	logic [PAGE_W-1:0]     alloc_page;
	logic [STATUS_W-1:0]   status;
	logic [REF_W-1:0]      ref_count;
	logic                  page_freed;
	logic                  cfg_valid = 1'b0;
	logic                  cfg_ready;
	logic [CFG_IDX_W-1:0]  cfg_index = '0;
	logic [CFG_DATA_W-1:0] cfg_data = '0;

	int outstanding;
	int fail_count;
	int checked;

	// shared between the sender and receiver processes
	bit tx_fast = 1'b0;     // sender: no gaps while set
	int hold_off = 0;       // receiver: one long stall when nonzero
	int win_lo = 0;         // current first_page
	int win_hi = MAX_PAGES; // current page_limit
	int items_sent = 0;
	int reg_writes = 0;
	int cycles = 0;

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	page_allocator_refcount uut (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.opcode     (opcode),
		.page_index (page_index),
		.empty      (empty),
		.pop        (pop),
		.alloc_page (alloc_page),
		.status     (status),
		.ref_count  (ref_count),
		.page_freed (page_freed),
		.cfg_valid  (cfg_valid),
		.cfg_ready  (cfg_ready),
		.cfg_index  (cfg_index),
		.cfg_data   (cfg_data)
	);

	page_alloc_checker u_checker (
		.clk         (clk),
		.arst_n      (arst_n),
		.push        (push),
		.full        (full),
		.opcode      (opcode),
		.page_index  (page_index),
		.pop         (pop),
		.empty       (empty),
		.alloc_page  (alloc_page),
		.status      (status),
		.ref_count   (ref_count),
		.page_freed  (page_freed),
		.cfg_valid   (cfg_valid),
		.cfg_ready   (cfg_ready),
		.cfg_index   (cfg_index),
		.cfg_data    (cfg_data),
		.outstanding (outstanding),
		.fail_count  (fail_count),
		.checked     (checked)
	);

	// Watchdog. Also covers a DUT that never drops full after the
	// clearing pass, or loses a result so outstanding never drains.
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= LIMIT) begin
			$display("timeout after %0d cycles, %0d results still expected",
				cycles, outstanding);
			$display("CHECKS FAILED");
			$finish;
		end
	end

	// Offer one item; returns at the edge that took it. push is left high
	// so back-to-back items keep it asserted without a glitch.
	task automatic send_item(input opcode_t op, input logic [PAGE_W-1:0] pg);
		int gap;
		gap = tx_fast ? 0 : $urandom_range(0, 7);
		if (gap > 0) begin
			push <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		push <= 1'b1;
		opcode <= op;
		page_index <= pg;
		@(posedge clk);
		while (full) @(posedge clk);
		items_sent++;
	endtask

	// Stop offering and wait for every expected result. The first edge lets
	// the checker's count catch up with an item taken on the calling edge.
	task automatic settle();
		push <= 1'b0;
		@(posedge clk);
		while (outstanding != 0) @(posedge clk);
		repeat (6) @(posedge clk); // pipeline is ~2 deep, give it margin
	endtask

	// valid stays high between the two writes; caller drops it
	task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input int val);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= CFG_DATA_W'(val);
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		reg_writes++;
	endtask

	// Registers only change with the block idle.
	task automatic set_window(input int lo, input int hi);
		settle();
		put_reg(CFG_FIRST_PAGE, lo);
		put_reg(CFG_PAGE_LIMIT, hi);
		cfg_valid <= 1'b0;
		win_lo = lo;
		win_hi = hi;
	endtask

	// Mostly a small hot set at the bottom of the window so counts and the
	// stack see real reuse; then window edges; then anything at all.
	function automatic logic [PAGE_W-1:0] pick_page();
		int span;
		int sel;
		int p;
		span = win_hi - win_lo;
		sel = $urandom_range(0, 99);
		if (sel < 60 && span > 0) begin
			p = win_lo + $urandom_range(0, (span < 16 ? span : 16) - 1);
		end else if (sel < 75) begin
			case ($urandom_range(0, 3))
				0: p = win_lo - 1;
				1: p = win_lo;
				2: p = win_hi - 1;
				default: p = win_hi;
			endcase
		end else begin
			p = $urandom_range(0, TOP_PAGE);
		end
		return PAGE_W'(p); // edges past the index range simply wrap
	endfunction

	function automatic opcode_t pick_op();
		int sel;
		sel = $urandom_range(0, 99);
		if (sel < 25)
			return OP_ALLOC;
		else if (sel < 45)
			return OP_FREE;
		else if (sel < 75)
			return OP_INCREF;
		return OP_DECREF;
	endfunction

	// Result side: random stall per item, occasional no-stall stretches,
	// and one long hold-off when the sender asks for it.
	initial begin : result_drain
		int  hold;
		int  taken;
		bit  rx_fast;
		taken = 0;
		rx_fast = 1'b0;
		wait (arst_n);
		@(posedge clk);
		forever begin
			if (hold_off > 0) begin
				hold = hold_off;
				hold_off = 0;
			end else if (rx_fast) begin
				hold = 0;
			end else begin
				hold = $urandom_range(0, 7);
			end
			if (hold > 0) begin
				pop <= 1'b0;
				repeat (hold) @(posedge clk);
			end
			pop <= 1'b1;
			@(posedge clk);
			while (empty) @(posedge clk);
			taken++;
			if (taken % 40 == 0)
				rx_fast = ($urandom_range(0, 2) == 0);
		end
	end

	initial begin : stimulus
		int lo;
		int hi;
		int n;
		int phase;
		int first_random;
		logic [PAGE_W-1:0] ramp_pg;

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// ---- directed: reset window (0, MAX_PAGES) ----
		// Sends stall on full through the count-table clearing pass.
		send_item(OP_ALLOC, '0);                    // empty stack
		send_item(OP_ALLOC, '1);                    // page bits ignored
		send_item(OP_FREE, '0);                     // lowest page
		send_item(OP_FREE, PAGE_W'(TOP_PAGE));      // highest page
		send_item(OP_INCREF, PAGE_W'(TOP_PAGE));    // 0 -> 1
		send_item(OP_DECREF, PAGE_W'(TOP_PAGE));    // 1 -> 0, pushed
		send_item(OP_DECREF, PAGE_W'(TOP_PAGE));    // stuck at 0, pushed again
		send_item(OP_FREE, PAGE_W'(TOP_PAGE));      // double free, no check
		repeat (5) send_item(OP_ALLOC, '0);         // LIFO order, count -> 1
		send_item(OP_ALLOC, '0);                    // empty again

		// narrow window: both edges in and out
		set_window(10, 20);
		send_item(OP_FREE, PAGE_W'(9));
		send_item(OP_FREE, PAGE_W'(10));
		send_item(OP_INCREF, PAGE_W'(19));
		send_item(OP_DECREF, PAGE_W'(20));
		send_item(OP_FREE, PAGE_W'(TOP_PAGE));

		// register extremes
		set_window(TOP_PAGE, MAX_PAGES);
		send_item(OP_FREE, PAGE_W'(TOP_PAGE));
		send_item(OP_INCREF, PAGE_W'(TOP_PAGE - 1));
		set_window(0, 0);
		send_item(OP_INCREF, '0);                   // nothing is in range
		send_item(OP_ALLOC, '0);                    // alloc has no range check

		// ---- random phases, each under its own window ----
		first_random = items_sent;
		phase = 0;
		while (items_sent - first_random < 1650) begin
			case (phase % 4)
				0: begin
					lo = 0;
					hi = MAX_PAGES;
				end
				1: begin
					lo = $urandom_range(0, TOP_PAGE);
					hi = $urandom_range(lo, MAX_PAGES);
				end
				2: begin
					lo = $urandom_range(0, MAX_PAGES - 16);
					hi = lo + $urandom_range(1, 16);
				end
				default: begin
					lo = $urandom_range(0, TOP_PAGE);
					hi = $urandom_range(0, lo); // empty window
				end
			endcase
			set_window(lo, hi);
			tx_fast = ($urandom_range(0, 1) == 0);

			if (phase == 1) begin
				// receiver sits out while we flood: queue fills, full rises
				tx_fast = 1'b1;
				hold_off = 300;
			end
			if (phase == 2) begin
				// walk one page up into saturation and back down past zero
				ramp_pg = PAGE_W'(lo);
				repeat (260) send_item(OP_INCREF, ramp_pg);
				repeat (262) send_item(OP_DECREF, ramp_pg);
			end

			n = (phase % 4 == 3) ? 40 : $urandom_range(150, 300);
			repeat (n) begin
				if ($urandom_range(0, 63) == 0)
					tx_fast = !tx_fast;
				send_item(pick_op(), pick_page());
			end
			phase++;
		end

		settle();
		repeat (10) @(posedge clk);

		$display("Sent %0d items, checked %0d results, %0d register writes over %0d windows.",
			items_sent, checked, reg_writes, phase + 3);
		$display("Included empty free stack, out-of-range pages, count saturation, stalls.");
		if (fail_count == 0 && outstanding == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule

// ===== filelist.f =====
hw/rtl/pal_pkg.sv
hw/rtl/pal_front.sv
hw/rtl/pal_back.sv
hw/rtl/page_allocator_refcount.sv
sim/page_alloc_checker.sv
sim/tb_page_allocator_refcount.sv
